// ===== rtl/ehf_pkg.sv =====
`default_nettype none

package ehf_pkg;

  localparam int HDR_LEN     = 14;
  localparam int CNT_W       = $clog2(HDR_LEN + 1);
  localparam int IDX_W       = $clog2(HDR_LEN);
  localparam int MAC_W       = 48;
  localparam int TYPE_W      = 16;
  localparam int HDR_W       = 2 * MAC_W + TYPE_W;
  localparam int DATA_W      = 64;
  localparam int PADDR_W     = 5;
  localparam int QUEUE_DEPTH = 2;

  // Byte positions within the header
  localparam int SRC_POS  = 6;
  localparam int TYPE_POS = 12;

  localparam logic [7:0] BYTE_MASK = 8'hFF;

  // Register indexes (taken from paddr[4:3])
  typedef enum logic [1:0] {
    REG_LOCAL_MAC = 2'd0,
    REG_ARP_TYPE  = 2'd1,
    REG_IP_TYPE   = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_e;

  localparam logic [TYPE_W-1:0] ARP_TYPE_RST = 16'h0806;
  localparam logic [TYPE_W-1:0] IP_TYPE_RST  = 16'h0800;

  typedef enum logic [1:0] {
    VERDICT_NONE = 2'd0,
    VERDICT_ARP  = 2'd1,
    VERDICT_IP   = 2'd2,
    VERDICT_RSVD = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [MAC_W-1:0]  local_mac;
    logic [TYPE_W-1:0] arp_ethertype;
    logic [TYPE_W-1:0] ip_ethertype;
  } cfg_t;

  // One classified header handed from front to back
  typedef struct packed {
    verdict_e          verdict;
    logic [MAC_W-1:0]  sender_addr;
    logic [MAC_W-1:0]  local_mac;
    logic [TYPE_W-1:0] type_field;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/ehf_regs.sv =====
`default_nettype none

module ehf_regs (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [ehf_pkg::PADDR_W-1:0] paddr,
  input  wire  [ehf_pkg::DATA_W-1:0]  pwdata,
  output logic [ehf_pkg::DATA_W-1:0]  prdata,
  output ehf_pkg::cfg_t               cfg_o
);
  import ehf_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[PADDR_W-1:PADDR_W-2]);
  assign wr_en = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_LOCAL_MAC: cfg_d.local_mac     = pwdata[MAC_W-1:0];
        REG_ARP_TYPE:  cfg_d.arp_ethertype = pwdata[TYPE_W-1:0];
        REG_IP_TYPE:   cfg_d.ip_ethertype  = pwdata[TYPE_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LOCAL_MAC: prdata = DATA_W'(cfg_q.local_mac);
      REG_ARP_TYPE:  prdata = DATA_W'(cfg_q.arp_ethertype);
      REG_IP_TYPE:   prdata = DATA_W'(cfg_q.ip_ethertype);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.local_mac     <= '0;
      cfg_q.arp_ethertype <= ARP_TYPE_RST;
      cfg_q.ip_ethertype  <= IP_TYPE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/ehf_front.sv =====
`default_nettype none

module ehf_front (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            accept_i,
  input  ehf_pkg::in_t   rx_i,
  input  ehf_pkg::cfg_t  cfg_i,
  output logic           job_push_o,
  output ehf_pkg::job_t  job_o
);
  import ehf_pkg::*;

  logic [CNT_W-1:0]  count_q, count_d, cnt;
  logic [MAC_W-1:0]  dest_q, dest_d;
  logic [MAC_W-1:0]  sender_q, sender_d;
  logic [TYPE_W-1:0] type_q, type_d;
  logic              in_hdr;

  assign cnt    = rx_i.frame_start ? '0 : count_q;
  assign in_hdr = cnt < CNT_W'(HDR_LEN);

  always_comb begin
    count_d  = count_q;
    dest_d   = dest_q;
    sender_d = sender_q;
    type_d   = type_q;
    if (accept_i) begin
      if (!in_hdr) begin
        count_d = CNT_W'(HDR_LEN);
      end else begin
        count_d = cnt + CNT_W'(1);
        if (cnt < CNT_W'(SRC_POS)) begin
          dest_d = {dest_q[MAC_W-9:0], rx_i.rx_byte};
        end else if (cnt < CNT_W'(TYPE_POS)) begin
          sender_d = {sender_q[MAC_W-9:0], rx_i.rx_byte};
        end else begin
          type_d = {type_q[TYPE_W-9:0], rx_i.rx_byte};
        end
      end
    end
  end

  // Classify on the final header byte; ARP wins over IP
  assign job_push_o = accept_i && (cnt == CNT_W'(HDR_LEN - 1));

  always_comb begin
    job_o.sender_addr = sender_q;
    job_o.local_mac   = cfg_i.local_mac;
    job_o.type_field  = type_d;
    if (type_d == cfg_i.arp_ethertype) begin
      job_o.verdict = VERDICT_ARP;
    end else if (type_d == cfg_i.ip_ethertype && dest_q == cfg_i.local_mac) begin
      job_o.verdict = VERDICT_IP;
    end else begin
      job_o.verdict = VERDICT_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      dest_q   <= '0;
      sender_q <= '0;
      type_q   <= '0;
    end else begin
      count_q  <= count_d;
      dest_q   <= dest_d;
      sender_q <= sender_d;
      type_q   <= type_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ehf_queue.sv =====
`default_nettype none

module ehf_queue (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  ehf_pkg::job_t  data_i,
  output logic           full_o,
  input  wire            pop_i,
  output logic           valid_o,
  output ehf_pkg::job_t  data_o
);
  import ehf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [LVL_W-1:0] level_q, level_d;
  logic             do_push, do_pop;

  assign full_o  = level_q == LVL_W'(QUEUE_DEPTH);
  assign valid_o = level_q != '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem[rd_ptr_q];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    level_d  = level_q;
    if (do_push && !do_pop) begin
      level_d = level_q + LVL_W'(1);
    end else if (do_pop && !do_push) begin
      level_d = level_q - LVL_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ehf_back.sv =====
`default_nettype none

module ehf_back (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            job_valid_i,
  input  ehf_pkg::job_t  job_i,
  output logic           job_pop_o,
  output logic           empty_o,
  input  wire            pop_i,
  output ehf_pkg::out_t  result_o
);
  import ehf_pkg::*;

  job_t             job_q;
  logic             busy_q;
  logic [IDX_W-1:0] idx_q;
  logic             out_valid_q;
  out_t             out_q;

  logic [HDR_W-1:0] hdr;
  logic [7:0]       hdr_bytes [HDR_LEN];
  logic             advance, last_now, finish;
  out_t             res;

  assign hdr = {job_q.sender_addr, job_q.local_mac, job_q.type_field};

  // Split the reply header into wire-order bytes
  always_comb begin
    for (int k = 0; k < HDR_LEN; k++) begin
      hdr_bytes[k] = hdr[HDR_W-1-8*k -: 8];
    end
  end

  assign last_now = (job_q.verdict != VERDICT_IP) || (idx_q == IDX_W'(HDR_LEN - 1));

  always_comb begin
    res.verdict = job_q.verdict;
    res.last    = last_now;
    if (job_q.verdict == VERDICT_IP) begin
      res.tx_valid = 1'b1;
      res.tx_byte  = hdr_bytes[idx_q] & BYTE_MASK;
    end else begin
      res.tx_valid = 1'b0;
      res.tx_byte  = '0;
    end
  end

  assign advance   = !out_valid_q || pop_i;
  assign finish    = busy_q && advance && last_now;
  assign job_pop_o = job_valid_i && (!busy_q || finish);

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    if (advance && busy_q) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= busy_q;
      end
      if (job_pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (finish) begin
        busy_q <= 1'b0;
      end else if (busy_q && advance) begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  assign empty_o  = !out_valid_q;
  assign result_o = out_q;

endmodule

`default_nettype wire

// ===== rtl/ethernet_header_filter_reply.sv =====
// A header's result passes the job queue, then the back stage's job and output registers.
// Throughput: one received byte per cycle unless full; one result per cycle unless pop is low,
// so an IP reply is 14 output results while the front keeps classifying the next frame.
// The input stalls (full high) only while the two-entry job queue is full.
// Reset: asynchronous, active low; clears the byte counter, captured fields, queue and output
// stage, and loads the registers with local MAC 0, ARP type 0x0806 and IP type 0x0800.
`default_nettype none

module ethernet_header_filter_reply (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  // Byte input, queue style
  input  wire                         push,
  output logic                        full,
  input  ehf_pkg::in_t                rx_i,
  // Result output, queue style
  output logic                        empty,
  input  wire                         pop,
  output ehf_pkg::out_t               result_o,
  // Configuration port
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [ehf_pkg::PADDR_W-1:0] paddr,
  input  wire  [ehf_pkg::DATA_W-1:0]  pwdata,
  output logic [ehf_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import ehf_pkg::*;

  cfg_t cfg;
  job_t job_in, job_out;
  logic accept, job_push, job_full, job_valid, job_pop;

  // The APB port never inserts wait states
  assign pready = 1'b1;

  ehf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // Hold the byte stream whenever the job queue cannot take another header
  assign full   = job_full;
  assign accept = push && !full;

  // Front: count, capture and classify header bytes
  ehf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_i       (rx_i),
    .cfg_i      (cfg),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  // Decouple classification from reply emission
  ehf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .data_o  (job_out)
  );

  // Back: turn each job into one verdict result or a 14-byte reply header
  ehf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

// ===== rtl/ehf_checker.sv =====
`default_nettype none

module ehf_checker (
  input wire           clk_i,
  input wire           rst_ni,
  input wire           empty,
  input wire           pop,
  input ehf_pkg::out_t result_o,
  input wire           pready
);
  import ehf_pkg::*;

  // A result without a transmit byte is always the only one of its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !result_o.tx_valid) |-> (result_o.last && result_o.tx_byte == '0))
    else $error("result without tx byte is not a lone last result");

  // Transmit bytes appear for IP verdicts only, and IP always carries a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.tx_valid == (result_o.verdict == VERDICT_IP)))
    else $error("tx_valid disagrees with verdict");

  // Within a reply header the verdict stays IP from one transfer to the next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && result_o.tx_valid && !result_o.last) ##1 !empty
      |-> result_o.verdict == VERDICT_IP)
    else $error("reply header broken before its last byte");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind ethernet_header_filter_reply ehf_checker u_ehf_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o),
  .pready   (pready)
);

`default_nettype wire

// ===== tb/ethernet_header_filter_reply_tb.sv =====
`timescale 1ns / 1ps

module ethernet_header_filter_reply_tb;
  import ehf_pkg::*;

  // Tracks the header parser and the register file. It predicts the verdict and
  // reply bytes for each complete header, and holds them until the block hands
  // them over.
  class reply_tracker;
    logic [MAC_W-1:0]  local_mac;
    logic [TYPE_W-1:0] arp_type;
    logic [TYPE_W-1:0] ip_type;
    logic [CNT_W-1:0]  hdr_count;
    logic [MAC_W-1:0]  dest_mac;
    logic [MAC_W-1:0]  src_mac;
    logic [TYPE_W-1:0] rx_type;
    out_t              replies_due[$];
    int                mismatches;
    int                bytes_taken;
    int                results_seen;
    int                ip_frames;
    int                arp_frames;
    int                dropped_frames;

    function new();
      local_mac      = '0;
      arp_type       = ARP_TYPE_RST;
      ip_type        = IP_TYPE_RST;
      hdr_count      = '0;
      dest_mac       = '0;
      src_mac        = '0;
      rx_type        = '0;
      mismatches     = 0;
      bytes_taken    = 0;
      results_seen   = 0;
      ip_frames      = 0;
      arp_frames     = 0;
      dropped_frames = 0;
    endfunction

    function int outstanding();
      return replies_due.size();
    endfunction

    function void write_reg(reg_idx_e idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_LOCAL_MAC: local_mac = value[MAC_W-1:0];
        REG_ARP_TYPE:  arp_type  = value[TYPE_W-1:0];
        REG_IP_TYPE:   ip_type   = value[TYPE_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_rx_byte(in_t b);
      out_t             r;
      logic [HDR_W-1:0] reply_hdr;
      if (b.frame_start) hdr_count = '0;
      // header complete: drop everything until the next frame start
      if (hdr_count >= HDR_LEN) return;
      bytes_taken++;
      if (hdr_count < SRC_POS) dest_mac = {dest_mac[MAC_W-9:0], b.rx_byte};
      else if (hdr_count < TYPE_POS) src_mac = {src_mac[MAC_W-9:0], b.rx_byte};
      else rx_type = {rx_type[TYPE_W-9:0], b.rx_byte};
      hdr_count++;
      if (hdr_count != HDR_LEN) return;

      r.tx_valid = 1'b0;
      r.tx_byte  = '0;
      r.last     = 1'b1;
      if (rx_type == arp_type) begin
        r.verdict = VERDICT_ARP;
        replies_due.push_back(r);
        arp_frames++;
      end else if (rx_type != ip_type || dest_mac != local_mac) begin
        r.verdict = VERDICT_NONE;
        replies_due.push_back(r);
        dropped_frames++;
      end else begin
        reply_hdr = {src_mac, local_mac, rx_type};
        for (int i = 0; i < HDR_LEN; i++) begin
          r.verdict  = VERDICT_IP;
          r.tx_valid = 1'b1;
          r.tx_byte  = reply_hdr[HDR_W-1-8*i -: 8];
          r.last     = (i == HDR_LEN - 1);
          replies_due.push_back(r);
        end
        ip_frames++;
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_reply(out_t got);
      out_t want;
      results_seen++;
      if (replies_due.size() == 0) begin
        $display("%0t: result expected none, got %h", $time, got);
        mismatches++;
        return;
      end
      want = replies_due.pop_front();
      compare_field("verdict", 8'(want.verdict), 8'(got.verdict));
      compare_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
      compare_field("tx_byte", want.tx_byte, got.tx_byte);
      compare_field("last", 8'(want.last), 8'(got.last));
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                push;
  logic                full;
  in_t                 rx_i;
  logic                empty;
  logic                pop;
  out_t                result_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  reply_tracker tracker;
  bit           idle_on;
  int           settings_used;

  ethernet_header_filter_reply uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .rx_i     (rx_i),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Present one byte and hold it until the block takes it. Sampling straight
  // after the edge sees the pre-edge value of full, so the transfer is seen
  // exactly as the block sees it.
  task automatic send_byte(input in_t b);
    rx_i <= b;
    push <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    tracker.take_rx_byte(b);
  endtask

  // Drop push for a random burst now and then; never in the final phase.
  task automatic take_break();
    if (idle_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  task automatic send_header(input logic [MAC_W-1:0] dst, input logic [MAC_W-1:0] src,
                             input logic [TYPE_W-1:0] et, input bit mark_start);
    logic [HDR_W-1:0] hdr;
    in_t              b;
    hdr = {dst, src, et};
    for (int i = 0; i < HDR_LEN; i++) begin
      b.rx_byte     = hdr[HDR_W-1-8*i -: 8];
      b.frame_start = mark_start && (i == 0);
      send_byte(b);
      take_break();
    end
  endtask

  // Random bytes: a cut-short header when lead_start is set, stray frame
  // starts scattered about when stray_starts is set, else trailing payload.
  task automatic send_bytes(input int n, input bit lead_start, input bit stray_starts);
    in_t b;
    for (int i = 0; i < n; i++) begin
      b.rx_byte     = 8'($urandom_range(0, 255));
      b.frame_start = (lead_start && i == 0) ||
                      (stray_starts && $urandom_range(0, 3) == 0);
      send_byte(b);
      take_break();
    end
  endtask

  // Two-phase write: setup, then access; the register takes the value at the
  // edge where penable and pready are both high.
  task automatic apb_write(input reg_idx_e idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tracker.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold the input, wait for every expected result, then allow for a
  // classification still in flight from a byte that gave no result.
  task automatic settle();
    push <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [MAC_W-1:0] m;
    m[47:32] = 16'($urandom_range(0, 16'hFFFF));
    m[31:0]  = $urandom;
    return m;
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Mostly well-formed frames, many aimed at this station or near misses of it,
  // with the rest split between cut-short headers and loose noise.
  task automatic run_traffic(input int target);
    int               first;
    int               pick;
    logic [MAC_W-1:0] dst;
    logic [TYPE_W-1:0] et;
    first = tracker.bytes_taken;
    while (tracker.bytes_taken - first < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) dst = tracker.local_mac;
        else if (pick < 70) dst = tracker.local_mac ^ (48'd1 << $urandom_range(0, 47));
        else dst = rand_mac();
        pick = $urandom_range(0, 99);
        if (pick < 40) et = tracker.ip_type;
        else if (pick < 70) et = tracker.arp_type;
        else if (pick < 85) et = tracker.ip_type ^ (16'd1 << $urandom_range(0, 15));
        else et = 16'($urandom_range(0, 16'hFFFF));
        send_header(dst, rand_mac(), et, 1'b1);
        send_bytes($urandom_range(0, 3), 1'b0, 1'b0);
      end else if (pick < 85) begin
        send_bytes($urandom_range(1, 13), 1'b1, 1'b0);
      end else begin
        send_bytes($urandom_range(1, 6), 1'b0, 1'b1);
      end
    end
  endtask

  // Receive side: check every transfer, and stall pop in random bursts outside the final phase.
  initial begin
    int stall_left;
    stall_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) tracker.check_reply(result_o);
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    in_t               b;
    logic [TYPE_W-1:0] shared_type;
    tracker       = new();
    idle_on       = 1'b1;
    settings_used = 1;
    rst_ni  <= 1'b0;
    push    <= 1'b0;
    rx_i    <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset register values. The first header comes without a frame
    // start and must still parse from byte 0: all-zero destination matches the
    // reset local MAC, so an IP reply follows with an all-ones requester.
    send_header(48'h0, 48'hFFFF_FFFF_FFFF, IP_TYPE_RST, 1'b0);
    // trailing byte after a complete header is dropped
    b = '{rx_byte: 8'hFF, frame_start: 1'b0};
    send_byte(b);
    // cut a header short; the next frame start restarts the count
    b = '{rx_byte: 8'hAA, frame_start: 1'b1};
    send_byte(b);
    b = '{rx_byte: 8'h55, frame_start: 1'b0};
    send_byte(b);
    // ARP is accepted whatever the destination
    send_header(48'h0102_0304_0506, 48'hA5A5_5A5A_C3C3, ARP_TYPE_RST, 1'b1);
    run_traffic(50);

    // Extremes, written with junk in the unused upper bits to exercise masking.
    settle();
    apb_write(REG_LOCAL_MAC, 64'hFFFF_FFFF_FFFF_FFFF);
    apb_write(REG_ARP_TYPE, 64'h1234_5678_9ABC_FFFF);
    apb_write(REG_IP_TYPE, 64'h0);
    settings_used++;
    run_traffic(60);

    // Both ethertypes equal, so ARP wins; a write to the unmapped slot must
    // leave every register alone.
    settle();
    shared_type = 16'($urandom_range(0, 16'hFFFF));
    apb_write(REG_LOCAL_MAC, 64'h0);
    apb_write(REG_ARP_TYPE, {48'h0, shared_type});
    apb_write(REG_IP_TYPE, {48'h0, shared_type});
    apb_write(REG_NONE, rand_word());
    settings_used++;
    run_traffic(60);

    settle();
    apb_write(REG_LOCAL_MAC, {16'h0, rand_mac()});
    apb_write(REG_ARP_TYPE, 64'h0806);
    apb_write(REG_IP_TYPE, 64'h0800);
    settings_used++;
    run_traffic(60);

    settle();
    apb_write(REG_LOCAL_MAC, rand_word());
    apb_write(REG_ARP_TYPE, rand_word());
    apb_write(REG_IP_TYPE, rand_word());
    settings_used++;
    run_traffic(60);

    // Final stretch at full rate on both sides.
    settle();
    apb_write(REG_LOCAL_MAC, {16'h0, rand_mac()});
    apb_write(REG_ARP_TYPE, 64'h0806);
    apb_write(REG_IP_TYPE, 64'h86DD);
    settings_used++;
    idle_on = 1'b0;
    run_traffic(60);

    settle();
    $display("covered %0d header bytes and %0d results across %0d register settings",
             tracker.bytes_taken, tracker.results_seen, settings_used);
    $display("verdicts seen: %0d IP replies, %0d ARP, %0d dropped",
             tracker.ip_frames, tracker.arp_frames, tracker.dropped_frames);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("ethernet_header_filter_reply: match");
    end else begin
      $display("ethernet_header_filter_reply: mismatch");
    end
    $finish;
  end

  // The slowest correct run has every byte behind the longest break and every reply byte
  // behind the longest pop stall; the timeout allows far more.
  initial begin
    #2000000;
    $display("ethernet_header_filter_reply: mismatch");
    $finish;
  end

endmodule
